// ----- hdl/tvi_pkg.sv -----
// Shared types and constants of the timestamped vector interpolator.
package tvi_pkg;

    // request kinds on the input tuser
    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // source kinds on the output tuser
    localparam logic [1:0] SRC_INTERP  = 2'd0;
    localparam logic [1:0] SRC_NEWEST  = 2'd1;
    localparam logic [1:0] SRC_DEFAULT = 2'd2;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_FACTOR  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SHIFT   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RING_LEN = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LANE_CNT = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DEF_X   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DEF_Y   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_DEF_Z   = 3'd6;

    // fixed field widths
    localparam int VAL_W    = 32;
    localparam int TICK_W   = 32;
    localparam int IO_LANES = 3;
    localparam int W_FRAC   = 24;   // interpolation weight, Q1.24
    localparam int A_FRAC   = 16;   // smoothing factor, Q0.16
    localparam int PROD_W   = 59;   // 33-bit difference times 26-bit operand

    // sequencer states
    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_PREP     = 14'b00000000000010,
        ST_PUSH     = 14'b00000000000100,
        ST_SCAN_RD  = 14'b00000000001000,
        ST_SCAN_CHK = 14'b00000000010000,
        ST_NEW_RD   = 14'b00000000100000,
        ST_NEW_CHK  = 14'b00000001000000,
        ST_DIV_INIT = 14'b00000010000000,
        ST_DIV_STEP = 14'b00000100000000,
        ST_LANE_MI  = 14'b00001000000000,
        ST_LANE_AI  = 14'b00010000000000,
        ST_LANE_MA  = 14'b00100000000000,
        ST_LANE_AA  = 14'b01000000000000,
        ST_DONE     = 14'b10000000000000
    } state_t;

endpackage

// ----- hdl/tvi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/timestamped_vector_interpolator_core.sv -----
// Top level: timestamped vector ring, interpolation sequencer and smoothing.
//
// Input stream s_*: s_tuser carries the request kind (sample, tick, restart),
// s_tdata the tick and the three sample lanes. A sample request latches a
// pending vector; a restart empties the ring and reloads the smoothed vector
// from the default registers. Neither gives a result.
// A tick request pushes the pending vector into the ring memory, scans the
// ring oldest first, interpolates between the bracketing entries (or holds
// the newest entry, or uses the defaults) and smooths the pick per lane.
// It gives one result on m_*: m_tdata the three lanes, m_tuser the source.
// A tick walks the scanned ring entries, runs the bit-serial weight divider
// when interpolating and uses the shared multiplier per lane, then loads the
// output register. Ring walking goes through the registered memory read port.
// A shrunk ring length is cut back once, in the prepare step of a tick.
// The output register holds a result until m_tready; the next request is
// taken meanwhile, and a tick result waits in the sequencer until the
// output register is free. Reset is synchronous (aresetn low): ring empty,
// no pending vector, registers at their reset values.
module timestamped_vector_interpolator_core #(
    parameter int RING_DEPTH = 16,
    parameter int LANES      = 3,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [127:0]                s_tdata,   // tick, sample_x, sample_y, sample_z
    input  logic [1:0]                  s_tuser,   // req_type
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [95:0]                 m_tdata,   // out_x, out_y, out_z
    output logic [1:0]                  m_tuser,   // source_kind
    // configuration writes
    input  logic                        cfg_wr_en,
    input  logic [tvi_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [tvi_pkg::CFG_DW-1:0]  cfg_data
);

    localparam int HW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LCW = $clog2(LANES + 1);
    localparam int RW  = LANES * tvi_pkg::VAL_W;

    // configuration
    logic [15:0]              factor_reg, factor_next;
    logic [15:0]              shift_reg, shift_next;
    logic [4:0]               ring_len_reg, ring_len_next;
    logic [1:0]               lane_cnt_reg, lane_cnt_next;
    logic signed [31:0]       def_reg [tvi_pkg::IO_LANES];
    logic signed [31:0]       def_next [tvi_pkg::IO_LANES];

    // control state
    tvi_pkg::state_t          state_reg, state_next;
    logic [HW-1:0]            head_reg, head_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [LCW-1:0]           lane_reg, lane_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic                     m_valid_reg, m_valid_next;

    // payload
    logic [31:0]              pend_stamp_reg, pend_stamp_next;
    logic signed [31:0]       pend_vals_reg [LANES];
    logic signed [31:0]       pend_vals_next [LANES];
    logic signed [31:0]       avg_reg [LANES];
    logic signed [31:0]       avg_next [LANES];
    logic signed [31:0]       lo_vals_reg [LANES];
    logic signed [31:0]       lo_vals_next [LANES];
    logic signed [31:0]       hi_vals_reg [LANES];
    logic signed [31:0]       hi_vals_next [LANES];
    logic signed [31:0]       pick_reg [LANES];
    logic signed [31:0]       pick_next [LANES];
    logic [31:0]              tick_reg, tick_next;
    logic [31:0]              lo_tick_reg, lo_tick_next;
    logic [31:0]              hi_tick_reg, hi_tick_next;
    logic [31:0]              den_reg, den_next;
    logic [31:0]              rem_reg, rem_next;
    logic [23:0]              quo_reg, quo_next;
    logic [24:0]              w_reg, w_next;
    logic [1:0]               kind_reg, kind_next;
    logic signed [tvi_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [95:0]              out_data_reg, out_data_next;
    logic [1:0]               out_kind_reg, out_kind_next;

    // memory ports
    logic                     mem_we;
    logic [HW-1:0]            mem_addr;
    logic [RW-1:0]            mem_wvals;
    logic [31:0]              rd_tick;
    logic [RW-1:0]            rd_vals;

    // derived values
    logic [CW-1:0]            cap;
    logic [LCW-1:0]           nl;
    logic [CW-1:0]            slot_off;
    logic [CW:0]              slot_sum;
    logic [LIW-1:0]           li;
    logic signed [32:0]       mul_a;
    logic signed [25:0]       mul_b;
    logic                     s_accept;

    function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
        if (v > 60'sh0_0000_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -60'sh0_0000_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // ring memories: stamps and packed lane vectors, one row per slot
    tvi_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_tick_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (pend_stamp_reg),
        .raddr (mem_addr),
        .rdata (rd_tick)
    );

    tvi_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_vals_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wvals),
        .raddr (mem_addr),
        .rdata (rd_vals)
    );

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mem_wvals[i*32 +: 32] = pend_vals_reg[i];
        end
    end

    // clamp ring length and lane count
    always_comb begin
        if (ring_len_reg == 5'd0) begin
            cap = CW'(1);
        end else if ({4'd0, ring_len_reg} > 9'(RING_DEPTH)) begin
            cap = CW'(RING_DEPTH);
        end else begin
            cap = CW'(ring_len_reg);
        end
        if (lane_cnt_reg == 2'd0) begin
            nl = LCW'(1);
        end else if ({1'b0, lane_cnt_reg} > 3'(LANES)) begin
            nl = LCW'(LANES);
        end else begin
            nl = LCW'(lane_cnt_reg);
        end
    end

    // slot address: (head + offset) mod cap, offset never above cap
    always_comb begin
        case (state_reg)
            tvi_pkg::ST_PUSH:   slot_off = fill_reg;
            tvi_pkg::ST_NEW_RD: slot_off = fill_reg - CW'(1);
            default:            slot_off = idx_reg;
        endcase
        slot_sum = (CW+1)'(head_reg) + (CW+1)'(slot_off);
        if (slot_sum >= (CW+1)'(cap)) begin
            slot_sum = slot_sum - (CW+1)'(cap);
        end
        mem_addr = slot_sum[HW-1:0];
    end

    // shared multiplier operands
    assign li = lane_reg[LIW-1:0];
    always_comb begin
        if (state_reg == tvi_pkg::ST_LANE_MI) begin
            mul_a = 33'(hi_vals_reg[li]) - 33'(lo_vals_reg[li]);
            mul_b = $signed({1'b0, w_reg});
        end else begin
            mul_a = 33'(pick_reg[li]) - 33'(avg_reg[li]);
            mul_b = $signed({10'd0, factor_reg});
        end
    end

    assign s_tready = (state_reg == tvi_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // sequencer
    always_comb begin
        logic [32:0]        num;
        logic [32:0]        rem2;
        logic signed [59:0] acc;
        logic               lane_last;
        logic               lane_used;

        factor_next     = factor_reg;
        shift_next      = shift_reg;
        ring_len_next   = ring_len_reg;
        lane_cnt_next   = lane_cnt_reg;
        def_next        = def_reg;
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        lane_next       = lane_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg;
        pend_stamp_next = pend_stamp_reg;
        pend_vals_next  = pend_vals_reg;
        avg_next        = avg_reg;
        lo_vals_next    = lo_vals_reg;
        hi_vals_next    = hi_vals_reg;
        pick_next       = pick_reg;
        tick_next       = tick_reg;
        lo_tick_next    = lo_tick_reg;
        hi_tick_next    = hi_tick_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        w_next          = w_reg;
        kind_next       = kind_reg;
        prod_next       = prod_reg;
        out_data_next   = out_data_reg;
        out_kind_next   = out_kind_reg;
        mem_we          = 1'b0;
        num             = '0;
        rem2            = '0;
        acc             = '0;
        lane_last       = (lane_reg == LCW'(LANES - 1));
        lane_used       = (lane_reg < nl);

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_index)
                tvi_pkg::CFG_FACTOR:   factor_next   = cfg_data[15:0];
                tvi_pkg::CFG_SHIFT:    shift_next    = cfg_data[15:0];
                tvi_pkg::CFG_RING_LEN: ring_len_next = cfg_data[4:0];
                tvi_pkg::CFG_LANE_CNT: lane_cnt_next = cfg_data[1:0];
                tvi_pkg::CFG_DEF_X:    def_next[0]   = cfg_data;
                tvi_pkg::CFG_DEF_Y:    def_next[1]   = cfg_data;
                tvi_pkg::CFG_DEF_Z:    def_next[2]   = cfg_data;
                default: ;
            endcase
        end

        // output register drains
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tvi_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        tvi_pkg::REQ_SAMPLE: begin
                            pend_stamp_next = s_tdata[31:0];
                            for (int i = 0; i < LANES; i++) begin
                                pend_vals_next[i] = (i < tvi_pkg::IO_LANES) ?
                                    s_tdata[32 + i*32 +: 32] : 32'sd0;
                            end
                            pend_valid_next = 1'b1;
                        end
                        tvi_pkg::REQ_TICK: begin
                            tick_next  = s_tdata[31:0];
                            state_next = tvi_pkg::ST_PREP;
                        end
                        tvi_pkg::REQ_RESTART: begin
                            head_next       = '0;
                            fill_next       = '0;
                            pend_valid_next = 1'b0;
                            for (int i = 0; i < LANES; i++) begin
                                avg_next[i] = (i < tvi_pkg::IO_LANES) ?
                                    def_reg[i] : 32'sd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // cut fill to length, reduce head modulo length
            tvi_pkg::ST_PREP: begin
                if (fill_reg > cap) begin
                    fill_next = cap;
                end else if (CW'(head_reg) >= cap) begin
                    head_next = HW'(CW'(head_reg) - cap);
                end else begin
                    state_next = tvi_pkg::ST_PUSH;
                end
            end

            // push pending vector at the tail slot
            tvi_pkg::ST_PUSH: begin
                if (pend_valid_reg) begin
                    mem_we          = 1'b1;
                    pend_valid_next = 1'b0;
                    if (fill_reg < cap) begin
                        fill_next = fill_reg + CW'(1);
                    end else if (CW'(head_reg) + CW'(1) == cap) begin
                        head_next = '0;
                    end else begin
                        head_next = head_reg + HW'(1);
                    end
                end
                idx_next   = '0;
                state_next = tvi_pkg::ST_SCAN_RD;
            end

            // issue read of the next entry, or finish the scan
            tvi_pkg::ST_SCAN_RD: begin
                if (idx_reg == fill_reg) begin
                    lane_next  = '0;
                    state_next = tvi_pkg::ST_LANE_MI;
                    if (fill_reg == '0) begin
                        kind_next = tvi_pkg::SRC_DEFAULT;
                        for (int i = 0; i < LANES; i++) begin
                            pick_next[i] = (i < tvi_pkg::IO_LANES) ? def_reg[i] : 32'sd0;
                        end
                    end else begin
                        kind_next = tvi_pkg::SRC_NEWEST;
                        pick_next = lo_vals_reg;
                    end
                end else begin
                    state_next = tvi_pkg::ST_SCAN_CHK;
                end
            end

            // compare stamp plus shift against the tick
            tvi_pkg::ST_SCAN_CHK: begin
                if ({1'b0, rd_tick} + {17'd0, shift_reg} >= {1'b0, tick_reg}) begin
                    if (idx_reg == '0) begin
                        state_next = tvi_pkg::ST_NEW_RD;
                    end else begin
                        hi_tick_next = rd_tick;
                        for (int i = 0; i < LANES; i++) begin
                            hi_vals_next[i] = rd_vals[i*32 +: 32];
                        end
                        state_next = tvi_pkg::ST_DIV_INIT;
                    end
                end else begin
                    lo_tick_next = rd_tick;
                    for (int i = 0; i < LANES; i++) begin
                        lo_vals_next[i] = rd_vals[i*32 +: 32];
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = tvi_pkg::ST_SCAN_RD;
                end
            end

            tvi_pkg::ST_NEW_RD: begin
                state_next = tvi_pkg::ST_NEW_CHK;
            end

            // newest entry held
            tvi_pkg::ST_NEW_CHK: begin
                kind_next = tvi_pkg::SRC_NEWEST;
                for (int i = 0; i < LANES; i++) begin
                    pick_next[i] = rd_vals[i*32 +: 32];
                end
                lane_next  = '0;
                state_next = tvi_pkg::ST_LANE_MI;
            end

            // weight numerator and denominator; full weight when past the upper
            tvi_pkg::ST_DIV_INIT: begin
                num      = {1'b0, tick_reg} - {1'b0, lo_tick_reg} - {17'd0, shift_reg};
                den_next = hi_tick_reg - lo_tick_reg;
                kind_next = tvi_pkg::SRC_INTERP;
                if (num >= {1'b0, den_next}) begin
                    w_next     = 25'(1) << tvi_pkg::W_FRAC;
                    lane_next  = '0;
                    state_next = tvi_pkg::ST_LANE_MI;
                end else begin
                    rem_next   = num[31:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = tvi_pkg::ST_DIV_STEP;
                end
            end

            // restoring division, one quotient bit a cycle
            tvi_pkg::ST_DIV_STEP: begin
                rem2 = {rem_reg, 1'b0};
                if (rem2 >= {1'b0, den_reg}) begin
                    rem_next = 32'(rem2 - {1'b0, den_reg});
                    quo_next = {quo_reg[22:0], 1'b1};
                end else begin
                    rem_next = rem2[31:0];
                    quo_next = {quo_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(tvi_pkg::W_FRAC - 1)) begin
                    w_next     = {1'b0, quo_next};
                    lane_next  = '0;
                    state_next = tvi_pkg::ST_LANE_MI;
                end
            end

            // interpolation product, or skip to smoothing
            tvi_pkg::ST_LANE_MI: begin
                if (kind_reg == tvi_pkg::SRC_INTERP) begin
                    prod_next  = mul_a * mul_b;
                    state_next = tvi_pkg::ST_LANE_AI;
                end else if (lane_used) begin
                    state_next = tvi_pkg::ST_LANE_MA;
                end else if (lane_last) begin
                    state_next = tvi_pkg::ST_DONE;
                end else begin
                    lane_next = lane_reg + LCW'(1);
                end
            end

            // round, add lower value, saturate
            tvi_pkg::ST_LANE_AI: begin
                acc = 60'(prod_reg) + (60'sd1 <<< (tvi_pkg::W_FRAC - 1));
                acc = (acc >>> tvi_pkg::W_FRAC) + 60'(lo_vals_reg[li]);
                pick_next[li] = sat32(acc);
                if (lane_used) begin
                    state_next = tvi_pkg::ST_LANE_MA;
                end else if (lane_last) begin
                    state_next = tvi_pkg::ST_DONE;
                end else begin
                    lane_next  = lane_reg + LCW'(1);
                    state_next = tvi_pkg::ST_LANE_MI;
                end
            end

            tvi_pkg::ST_LANE_MA: begin
                prod_next  = mul_a * mul_b;
                state_next = tvi_pkg::ST_LANE_AA;
            end

            // exponential average update
            tvi_pkg::ST_LANE_AA: begin
                acc = 60'(prod_reg) + (60'sd1 <<< (tvi_pkg::A_FRAC - 1));
                acc = (acc >>> tvi_pkg::A_FRAC) + 60'(avg_reg[li]);
                avg_next[li] = sat32(acc);
                if (lane_last) begin
                    state_next = tvi_pkg::ST_DONE;
                end else begin
                    lane_next  = lane_reg + LCW'(1);
                    state_next = tvi_pkg::ST_LANE_MI;
                end
            end

            // hand the result to the output register once it is free
            tvi_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    for (int i = 0; i < tvi_pkg::IO_LANES; i++) begin
                        if (i < LANES && 32'(i) < 32'(nl)) begin
                            out_data_next[i*32 +: 32] = avg_reg[i];
                        end else begin
                            out_data_next[i*32 +: 32] = 32'd0;
                        end
                    end
                    out_kind_next = kind_reg;
                    m_valid_next  = 1'b1;
                    state_next    = tvi_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tvi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tvi_pkg::ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            lane_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_stamp_reg <= '0;
            factor_reg     <= 16'd6554;
            shift_reg      <= 16'd0;
            ring_len_reg   <= 5'd16;
            lane_cnt_reg   <= 2'd3;
            def_reg[0]     <= 32'sd0;
            def_reg[1]     <= 32'sd0;
            def_reg[2]     <= 32'sd1 <<< FRAC_BITS;
            for (int i = 0; i < LANES; i++) begin
                pend_vals_reg[i] <= 32'sd0;
                avg_reg[i]       <= (i == 2) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            lane_reg       <= lane_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            pend_stamp_reg <= pend_stamp_next;
            factor_reg     <= factor_next;
            shift_reg      <= shift_next;
            ring_len_reg   <= ring_len_next;
            lane_cnt_reg   <= lane_cnt_next;
            def_reg        <= def_next;
            pend_vals_reg  <= pend_vals_next;
            avg_reg        <= avg_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        lo_vals_reg  <= lo_vals_next;
        hi_vals_reg  <= hi_vals_next;
        pick_reg     <= pick_next;
        tick_reg     <= tick_next;
        lo_tick_reg  <= lo_tick_next;
        hi_tick_reg  <= hi_tick_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        w_reg        <= w_next;
        kind_reg     <= kind_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

// ----- tb/sv/tb_timestamped_vector_interpolator_core.sv -----
// Testbench for the timestamped vector interpolator core: random stream traffic, self-checking.
`timescale 1ns / 1ps

module tb_timestamped_vector_interpolator_core;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 150;
    // request kind with no meaning, must be ignored
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic [31:0]        tick;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } request_t;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic [1:0]         src;
    } smoothed_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;     // tick, sample_x, sample_y, sample_z
    logic [1:0]   s_tuser = '0;     // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;          // out_x, out_y, out_z
    logic [1:0]   m_tuser;          // source_kind
    logic         cfg_wr_en = 1'b0;
    logic [tvi_pkg::CFG_AW-1:0] cfg_index = '0;
    logic [tvi_pkg::CFG_DW-1:0] cfg_data = '0;

    timestamped_vector_interpolator_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectations
    request_t  req_queue[$];
    smoothed_t smoothed_expect[$];
    request_t  cur_req;
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        quiet = 1'b0;

    // shadow registers and state of the interpolator
    logic [15:0]        alpha_q;
    logic [15:0]        shift_q;
    logic [4:0]         ring_len_q;
    logic [1:0]         lane_cnt_q;
    logic signed [31:0] dflt_q[3];
    logic [31:0]        stamp_ring[16];
    logic signed [31:0] lane_ring[16][3];
    int unsigned        ring_head;
    int unsigned        ring_fill;
    bit                 pend_ok;
    logic [31:0]        pend_stamp;
    logic signed [31:0] pend_lane[3];
    logic signed [31:0] avg_lane[3];

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic reset_shadow();
        alpha_q = 16'd6554;
        shift_q = 16'd0;
        ring_len_q = 5'd16;
        lane_cnt_q = 2'd3;
        dflt_q[0] = 0;
        dflt_q[1] = 0;
        dflt_q[2] = 32'sd65536;
        for (int i = 0; i < 16; i++) begin
            stamp_ring[i] = '0;
            for (int l = 0; l < 3; l++) lane_ring[i][l] = '0;
        end
        ring_head = 0;
        ring_fill = 0;
        pend_ok = 1'b0;
        pend_stamp = '0;
        for (int l = 0; l < 3; l++) begin
            pend_lane[l] = '0;
            avg_lane[l] = dflt_q[l];
        end
    endtask

    // apply one accepted request to the shadow state; ticks queue an expected result
    task automatic interpolate_request(input request_t rq);
        int unsigned cap, nl, found, slot, su, sl;
        longint unsigned num, den, w, a_t, b_t;
        longint lo, hi, prod, wt, diff;
        logic signed [31:0] pick[3];
        logic [1:0] src;
        smoothed_t res;
        case (rq.kind)
            tvi_pkg::REQ_SAMPLE: begin
                pend_lane[0] = rq.vx;
                pend_lane[1] = rq.vy;
                pend_lane[2] = rq.vz;
                pend_stamp = rq.tick;
                pend_ok = 1'b1;
            end
            tvi_pkg::REQ_RESTART: begin
                ring_head = 0;
                ring_fill = 0;
                pend_ok = 1'b0;
                for (int l = 0; l < 3; l++) avg_lane[l] = dflt_q[l];
            end
            tvi_pkg::REQ_TICK: begin
                cap = (ring_len_q == 0) ? 1 : (ring_len_q > 16) ? 16 : ring_len_q;
                nl = (lane_cnt_q == 0) ? 1 : lane_cnt_q;
                if (ring_fill > cap) ring_fill = cap;
                ring_head = ring_head % cap;
                // push the pending vector, overwriting the oldest when full
                if (pend_ok) begin
                    slot = (ring_head + ring_fill) % cap;
                    stamp_ring[slot] = pend_stamp;
                    for (int l = 0; l < 3; l++) lane_ring[slot][l] = pend_lane[l];
                    if (ring_fill < cap) ring_fill++;
                    else ring_head = (ring_head + 1) % cap;
                    pend_ok = 1'b0;
                end
                // first entry, oldest first, whose stamp plus shift reaches the tick
                found = ring_fill;
                for (int i = 0; i < ring_fill; i++) begin
                    slot = (ring_head + i) % cap;
                    a_t = stamp_ring[slot];
                    if (a_t + shift_q >= longint'(rq.tick)) begin
                        found = i;
                        break;
                    end
                end
                if (found < ring_fill && found > 0) begin
                    su = (ring_head + found) % cap;
                    sl = (ring_head + found - 1) % cap;
                    a_t = stamp_ring[sl];
                    b_t = stamp_ring[su];
                    num = longint'(rq.tick) - (a_t + shift_q);
                    den = b_t - a_t;
                    if (den == 0 || num >= den) w = 64'd1 << 24;
                    else w = (num << 24) / den;
                    wt = w;
                    for (int l = 0; l < 3; l++) begin
                        lo = lane_ring[sl][l];
                        hi = lane_ring[su][l];
                        prod = (hi - lo) * wt;
                        pick[l] = clamp32(lo + ((prod + 64'sd8388608) >>> 24));
                    end
                    src = tvi_pkg::SRC_INTERP;
                end else if (ring_fill > 0) begin
                    slot = (ring_head + ring_fill - 1) % cap;
                    for (int l = 0; l < 3; l++) pick[l] = lane_ring[slot][l];
                    src = tvi_pkg::SRC_NEWEST;
                end else begin
                    for (int l = 0; l < 3; l++) pick[l] = dflt_q[l];
                    src = tvi_pkg::SRC_DEFAULT;
                end
                // exponential average on the lanes in use
                for (int l = 0; l < nl; l++) begin
                    diff = longint'(pick[l]) - longint'(avg_lane[l]);
                    prod = diff * longint'({48'd0, alpha_q});
                    avg_lane[l] = clamp32(longint'(avg_lane[l]) + ((prod + 64'sd32768) >>> 16));
                end
                res.ox = avg_lane[0];
                res.oy = (nl > 1) ? avg_lane[1] : 32'sd0;
                res.oz = (nl > 2) ? avg_lane[2] : 32'sd0;
                res.src = src;
                smoothed_expect.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic int sender_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) interpolate_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    cur_req = req_queue.pop_front();
                    s_tdata <= {cur_req.vz, cur_req.vy, cur_req.vx, cur_req.tick};
                    s_tuser <= cur_req.kind;
                    s_tvalid <= 1'b1;
                    gap_left <= sender_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: short random stalls, rare long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (cycle_cnt == 3000 || $urandom_range(0, 2999) == 0) begin
            hold_left <= $urandom_range(300, 600);
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        smoothed_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (smoothed_expect.size() == 0) begin
                $error("unexpected result: tdata %h tuser %0d", m_tdata, m_tuser);
                err_cnt++;
            end else begin
                exp_r = smoothed_expect.pop_front();
                if (m_tdata[31:0] !== exp_r.ox) begin
                    $error("out_x mismatch: expected %0d, got %0d",
                           exp_r.ox, $signed(m_tdata[31:0]));
                    err_cnt++;
                end
                if (m_tdata[63:32] !== exp_r.oy) begin
                    $error("out_y mismatch: expected %0d, got %0d",
                           exp_r.oy, $signed(m_tdata[63:32]));
                    err_cnt++;
                end
                if (m_tdata[95:64] !== exp_r.oz) begin
                    $error("out_z mismatch: expected %0d, got %0d",
                           exp_r.oz, $signed(m_tdata[95:64]));
                    err_cnt++;
                end
                if (m_tuser !== exp_r.src) begin
                    $error("source_kind mismatch: expected %0d, got %0d", exp_r.src, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_timestamped_vector_interpolator_core: done, errors");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] kind, input logic [31:0] tick,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        request_t rq;
        rq.kind = kind;
        rq.tick = tick;
        rq.vx = x;
        rq.vy = y;
        rq.vz = z;
        req_queue.push_back(rq);
    endtask

    function automatic logic [31:0] lane_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        if (r < 4) return $urandom;
        return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
    endfunction

    // mostly rising stamps with ticks around them, some noise
    task automatic add_random(input int count, input logic [15:0] shf);
        logic [31:0] base, tk;
        int r;
        base = $urandom;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                add_req(tvi_pkg::REQ_RESTART, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 4) begin
                add_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 50) begin
                if ($urandom_range(0, 29) == 0) base = $urandom;
                else if ($urandom_range(0, 39) == 0) base = 32'hffffffff - $urandom_range(0, 40);
                else base = base + $urandom_range(0, 60);
                add_req(tvi_pkg::REQ_SAMPLE, base, lane_value(), lane_value(), lane_value());
            end else begin
                if ($urandom_range(0, 19) == 0) tk = $urandom;
                else tk = base + shf - $urandom_range(0, 200) + $urandom_range(0, 60);
                add_req(tvi_pkg::REQ_TICK, tk, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic write_reg(input logic [tvi_pkg::CFG_AW-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            tvi_pkg::CFG_FACTOR:   alpha_q = val[15:0];
            tvi_pkg::CFG_SHIFT:    shift_q = val[15:0];
            tvi_pkg::CFG_RING_LEN: ring_len_q = val[4:0];
            tvi_pkg::CFG_LANE_CNT: lane_cnt_q = val[1:0];
            tvi_pkg::CFG_DEF_X:    dflt_q[0] = val;
            tvi_pkg::CFG_DEF_Y:    dflt_q[1] = val;
            tvi_pkg::CFG_DEF_Z:    dflt_q[2] = val;
            default: ;
        endcase
    endtask

    // wait until every request went out and every result came back
    task automatic drain();
        while (req_queue.size() != 0 || s_tvalid || smoothed_expect.size() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // new register setting, then a restart so the ring starts empty
    task automatic run_phase(input logic [15:0] fac, input logic [15:0] shf,
                             input logic [4:0] len, input logic [1:0] lanes,
                             input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] dz, input bit calm);
        drain();
        write_reg(tvi_pkg::CFG_FACTOR, fac);
        write_reg(tvi_pkg::CFG_SHIFT, shf);
        write_reg(tvi_pkg::CFG_RING_LEN, len);
        write_reg(tvi_pkg::CFG_LANE_CNT, lanes);
        write_reg(tvi_pkg::CFG_DEF_X, dx);
        write_reg(tvi_pkg::CFG_DEF_Y, dy);
        write_reg(tvi_pkg::CFG_DEF_Z, dz);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        quiet = calm;
        add_req(tvi_pkg::REQ_RESTART, 0, 0, 0, 0);
        add_random(153, shf);
    endtask

    initial begin
        reset_shadow();
        // directed: default, held newest, interpolation, wrap-free stamp compare
        add_req(tvi_pkg::REQ_TICK, 100, 0, 0, 0);
        add_req(REQ_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_req(tvi_pkg::REQ_SAMPLE, 1000, 32'h7fffffff, 32'h80000000, 0);
        add_req(tvi_pkg::REQ_TICK, 500, 0, 0, 0);
        add_req(tvi_pkg::REQ_SAMPLE, 2000, 32'hffffffff, 1, 32'h7fffffff);
        add_req(tvi_pkg::REQ_SAMPLE, 2000, 32'h80000000, 32'h7fffffff, 12345);
        add_req(tvi_pkg::REQ_TICK, 1500, 0, 0, 0);
        add_req(tvi_pkg::REQ_TICK, 5000, 0, 0, 0);
        add_req(tvi_pkg::REQ_SAMPLE, 32'hffffffff, 0, 32'h00010000, 32'hffff0000);
        add_req(tvi_pkg::REQ_TICK, 32'hffffffff, 0, 0, 0);
        add_req(tvi_pkg::REQ_SAMPLE, 0, 32'h12345678, 32'h80000000, 32'h7fffffff);
        add_req(tvi_pkg::REQ_TICK, 32'h80000000, 0, 0, 0);
        add_req(tvi_pkg::REQ_TICK, 0, 0, 0, 0);
        add_req(tvi_pkg::REQ_RESTART, 0, 0, 0, 0);
        add_req(tvi_pkg::REQ_TICK, 7, 0, 0, 0);
        add_req(tvi_pkg::REQ_SAMPLE, 10, 32'h00020000, 32'hfffe0000, 32'h00008000);
        add_req(tvi_pkg::REQ_TICK, 10, 0, 0, 0);
        add_req(tvi_pkg::REQ_SAMPLE, 30, 32'h00040000, 32'h7fffffff, 32'h80000000);
        add_req(tvi_pkg::REQ_TICK, 25, 0, 0, 0);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        run_phase(16'd6554, 16'd0, 5'd16, 2'd3, 32'd0, 32'd0, 32'd65536, 1'b0);
        run_phase(16'd1, 16'd65535, 5'd1, 2'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
        run_phase(16'd65535, 16'd0, 5'd31, 2'd3, 32'h7fffffff, 32'h80000000, 32'd0, 1'b0);
        run_phase(16'd32768, 16'd100, 5'd0, 2'd0, 32'hfff00000, 32'h00100000, 32'h55555555,
                  1'b0);
        run_phase(16'd20000, 16'd7, 5'd5, 2'd2, 32'h00030000, 32'haaaaaaaa, 32'h00000001,
                  1'b1);
        run_phase(16'd65535, 16'd65535, 5'd16, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  1'b0);
        run_phase(16'd3000, 16'd300, 5'd2, 2'd3, 32'h0001ffff, 32'hfffe0001, 32'h00010000,
                  1'b0);
        run_phase(16'd40000, 16'd0, 5'd17, 2'd1, 32'hdeadbeef, 32'h00000000, 32'h7ffffffe,
                  1'b0);

        while (req_queue.size() != 0 || s_tvalid || smoothed_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb_timestamped_vector_interpolator_core: done, clean");
        end else begin
            $display("tb_timestamped_vector_interpolator_core: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tvi_pkg.sv
hdl/tvi_ram.sv
hdl/timestamped_vector_interpolator_core.sv
tb/sv/tb_timestamped_vector_interpolator_core.sv
